// ----- hw/rtl/pmsg_pkg.sv -----
// shared types, constants and the stroke table of the point marker stroke generator
`default_nettype none
package pmsg_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;
	localparam int unsigned STEP_W = 4;

	// floor(n / 3) = (n * DIV3_MUL) >> DIV3_SHIFT for n below 2^21
	localparam int unsigned DIV3_SHIFT = 23;
	localparam logic [21:0] DIV3_MUL = 22'd2796203;

	typedef enum logic [1:0] {
		REG_SCALE = 2'd0,
		REG_HTIC  = 2'd1,
		REG_VTIC  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		K_PLUS     = 3'd0,
		K_CROSS    = 3'd1,
		K_STAR     = 3'd2,
		K_BOX      = 3'd3,
		K_DIAMOND  = 3'd4,
		K_TRIANGLE = 3'd5,
		K_DOT      = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		XS_C   = 3'd0,
		XS_MH  = 3'd1,
		XS_PH  = 3'd2,
		XS_MH4 = 3'd3,
		XS_PH4 = 3'd4
	} xsel_t;

	typedef enum logic [2:0] {
		YS_C   = 3'd0,
		YS_MV  = 3'd1,
		YS_PV  = 3'd2,
		YS_PV4 = 3'd3,
		YS_MV2 = 3'd4
	} ysel_t;

	typedef struct packed {
		logic  pen;
		xsel_t xsel;
		ysel_t ysel;
		logic  last;
	} cmd_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] x;
		logic [FIELD_W-1:0] y;
		logic [FIELD_W-1:0] h;
		logic [FIELD_W-1:0] v;
		logic [FIELD_W-1:0] h4;
		logic [FIELD_W-1:0] v4;
		logic [FIELD_W-1:0] v2;
	} job_t;

	function automatic cmd_t mk(input logic pen, input xsel_t xs, input ysel_t ys,
			input logic last);
		cmd_t c;
		c.pen = pen;
		c.xsel = xs;
		c.ysel = ys;
		c.last = last;
		return c;
	endfunction

	function automatic cmd_t stroke_cmd(input kind_t kind, input logic [STEP_W-1:0] step);
		cmd_t c;
		c = mk(1'b1, XS_C, YS_C, 1'b1);
		unique case (kind)
			K_PLUS: begin
				unique case (step)
					4'd0: c = mk(1'b0, XS_MH, YS_C, 1'b0);
					4'd1: c = mk(1'b1, XS_MH, YS_C, 1'b0);
					4'd2: c = mk(1'b1, XS_PH, YS_C, 1'b0);
					4'd3: c = mk(1'b0, XS_C, YS_MV, 1'b0);
					4'd4: c = mk(1'b1, XS_C, YS_MV, 1'b0);
					default: c = mk(1'b1, XS_C, YS_PV, 1'b1);
				endcase
			end
			K_CROSS: begin
				unique case (step)
					4'd0: c = mk(1'b0, XS_MH, YS_MV, 1'b0);
					4'd1: c = mk(1'b1, XS_MH, YS_MV, 1'b0);
					4'd2: c = mk(1'b1, XS_PH, YS_PV, 1'b0);
					4'd3: c = mk(1'b0, XS_MH, YS_PV, 1'b0);
					4'd4: c = mk(1'b1, XS_MH, YS_PV, 1'b0);
					default: c = mk(1'b1, XS_PH, YS_MV, 1'b1);
				endcase
			end
			K_STAR: begin
				unique case (step)
					4'd0: c = mk(1'b0, XS_MH, YS_C, 1'b0);
					4'd1: c = mk(1'b1, XS_MH, YS_C, 1'b0);
					4'd2: c = mk(1'b1, XS_PH, YS_C, 1'b0);
					4'd3: c = mk(1'b0, XS_C, YS_MV, 1'b0);
					4'd4: c = mk(1'b1, XS_C, YS_MV, 1'b0);
					4'd5: c = mk(1'b1, XS_C, YS_PV, 1'b0);
					4'd6: c = mk(1'b0, XS_MH, YS_MV, 1'b0);
					4'd7: c = mk(1'b1, XS_MH, YS_MV, 1'b0);
					4'd8: c = mk(1'b1, XS_PH, YS_PV, 1'b0);
					4'd9: c = mk(1'b0, XS_MH, YS_PV, 1'b0);
					4'd10: c = mk(1'b1, XS_MH, YS_PV, 1'b0);
					default: c = mk(1'b1, XS_PH, YS_MV, 1'b1);
				endcase
			end
			K_BOX: begin
				unique case (step)
					4'd0: c = mk(1'b0, XS_MH, YS_MV, 1'b0);
					4'd1: c = mk(1'b1, XS_MH, YS_MV, 1'b0);
					4'd2: c = mk(1'b1, XS_PH, YS_MV, 1'b0);
					4'd3: c = mk(1'b1, XS_PH, YS_PV, 1'b0);
					4'd4: c = mk(1'b1, XS_MH, YS_PV, 1'b0);
					4'd5: c = mk(1'b1, XS_MH, YS_MV, 1'b0);
					4'd6: c = mk(1'b0, XS_C, YS_C, 1'b0);
					default: c = mk(1'b1, XS_C, YS_C, 1'b1);
				endcase
			end
			K_DIAMOND: begin
				unique case (step)
					4'd0: c = mk(1'b0, XS_MH, YS_C, 1'b0);
					4'd1: c = mk(1'b1, XS_C, YS_MV, 1'b0);
					4'd2: c = mk(1'b1, XS_PH, YS_C, 1'b0);
					4'd3: c = mk(1'b1, XS_C, YS_PV, 1'b0);
					4'd4: c = mk(1'b1, XS_MH, YS_C, 1'b0);
					4'd5: c = mk(1'b0, XS_C, YS_C, 1'b0);
					default: c = mk(1'b1, XS_C, YS_C, 1'b1);
				endcase
			end
			K_TRIANGLE: begin
				unique case (step)
					4'd0: c = mk(1'b0, XS_C, YS_PV4, 1'b0);
					4'd1: c = mk(1'b1, XS_MH4, YS_MV2, 1'b0);
					4'd2: c = mk(1'b1, XS_PH4, YS_MV2, 1'b0);
					4'd3: c = mk(1'b1, XS_C, YS_PV4, 1'b0);
					4'd4: c = mk(1'b0, XS_C, YS_C, 1'b0);
					default: c = mk(1'b1, XS_C, YS_C, 1'b1);
				endcase
			end
			default: begin
				unique case (step)
					4'd0: c = mk(1'b0, XS_C, YS_C, 1'b0);
					default: c = mk(1'b1, XS_C, YS_C, 1'b1);
				endcase
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/point_marker_stroke_generator_top.sv -----
// top level of the point marker stroke generator
`default_nettype none
// Turns a marker centre and symbol into the pen moves and draws that trace it.
// Input: x_pos, y_pos and symbol transfer on a clock edge with start high and
// busy low. Config: cfg_we writes cfg_data to register cfg_index
// (0 point_scale, 1 horiz_tic, 2 vert_tic); other indexes are dropped.
// Output: one pen command per cycle while strobe is high, last_command marks
// the final command of a marker. Commands of one marker come in adjacent
// cycles; the receiver cannot stall, each transfer lasts one cycle.
// A marker gives 2 (dot) to 12 (star) commands, which the back end issues
// one per cycle.
// From the input transfer to the first command an item passes three front
// stages (the first loading at the transfer edge), the queue write, the
// sequencer load and the output register, when the back end is idle.
// The front takes a new item every cycle while fewer than four items sit in
// its stages and the four entry queue; busy shows that limit.
// Reset: clears all control state and restores point_scale 256 and both tics
// to 100; no clearing pass is needed.
module point_marker_stroke_generator_top
	import pmsg_pkg::*;
#(
	parameter int unsigned MARKER_KINDS = 6,
	parameter int unsigned COORD_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [FIELD_W-1:0] x_pos,
	input  wire logic [FIELD_W-1:0] y_pos,
	input  wire logic signed [7:0]  symbol,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output logic                    strobe,
	output logic                    pen_command,
	output logic [FIELD_W-1:0]      out_x,
	output logic [FIELD_W-1:0]      out_y,
	output logic                    last_command
);

	logic push;
	logic pop;
	logic empty;
	job_t job_in;
	job_t job_head;

	pmsg_front #(
		.MARKER_KINDS(MARKER_KINDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.symbol(symbol),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pop(pop),
		.push(push),
		.job(job_in)
	);

	pmsg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(job_in),
		.pop(pop),
		.rdata(job_head),
		.empty(empty)
	);

	pmsg_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(job_head),
		.empty(empty),
		.pop(pop),
		.strobe(strobe),
		.pen_command(pen_command),
		.out_x(out_x),
		.out_y(out_y),
		.last_command(last_command)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/pmsg_queue.sv -----
// small job queue between the classifying front and the stroke sequencer
`default_nettype none
module pmsg_queue
	import pmsg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wdata,
	input  wire logic pop,
	output job_t      rdata,
	output logic      empty
);

	job_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign rdata = mem[rd_q];
	assign empty = (cnt_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < QCNT_W'(QDEPTH)) || pop)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- hw/rtl/pmsg_front.sv -----
// front end: config registers, item intake, size math and kind decode
`default_nettype none
module pmsg_front
	import pmsg_pkg::*;
#(
	parameter int unsigned MARKER_KINDS = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [FIELD_W-1:0] x_pos,
	input  wire logic [FIELD_W-1:0] y_pos,
	input  wire logic signed [7:0]  symbol,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               pop,
	output logic                    push,
	output job_t                    job
);

	// floor(s / MARKER_KINDS) = (s * MOD_MUL) >> 10 for s below 128
	localparam int unsigned MOD_MUL = (1024 + MARKER_KINDS - 1) / MARKER_KINDS;

	logic [15:0] point_scale_q;
	logic [11:0] horiz_tic_q;
	logic [11:0] vert_tic_q;

	logic [QCNT_W-1:0] credit_q;
	logic              accept;

	logic               valid_s1;
	logic [FIELD_W-1:0] x_s1;
	logic [FIELD_W-1:0] y_s1;
	logic [7:0]         sym_s1;
	logic [6:0]         quot_s1;
	logic [27:0]        prod_h_s1;
	logic [27:0]        prod_v_s1;

	logic               valid_s2;
	logic [FIELD_W-1:0] x_s2;
	logic [FIELD_W-1:0] y_s2;
	kind_t              kind_s2;
	logic [18:0]        h_s2;
	logic [18:0]        v_s2;

	logic               valid_s3;
	job_t               job_s3;

	logic [17:0] qprod;
	logic [9:0]  qk;
	logic [6:0]  rem;
	logic [42:0] h4_prod;
	logic [42:0] v4_prod;
	logic [42:0] v2_prod;

	assign accept = start && !busy;
	assign busy   = (credit_q == QCNT_W'(QDEPTH));

	assign qprod   = 18'(symbol[6:0]) * 18'(MOD_MUL);
	assign qk      = 10'(quot_s1) * 10'(MARKER_KINDS);
	assign rem     = sym_s1[6:0] - qk[6:0];
	assign h4_prod = 43'({h_s2, 2'b00}) * 43'(DIV3_MUL);
	assign v4_prod = 43'({v_s2, 2'b00}) * 43'(DIV3_MUL);
	assign v2_prod = 43'({v_s2, 1'b0}) * 43'(DIV3_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_scale_q <= 16'd256;
			horiz_tic_q   <= 12'd100;
			vert_tic_q    <= 12'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE: point_scale_q <= cfg_data;
				REG_HTIC:  horiz_tic_q   <= cfg_data[11:0];
				REG_VTIC:  vert_tic_q    <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// items in the pipe plus items in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			credit_q <= credit_q + QCNT_W'(accept) - QCNT_W'(pop);
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1      <= x_pos;
			y_s1      <= y_pos;
			sym_s1    <= symbol;
			quot_s1   <= qprod[16:10];
			prod_h_s1 <= 28'(point_scale_q) * 28'(horiz_tic_q);
			prod_v_s1 <= 28'(point_scale_q) * 28'(vert_tic_q);
		end
		if (valid_s1) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			h_s2 <= prod_h_s1[27:9];
			v_s2 <= prod_v_s1[27:9];
			kind_s2 <= sym_s1[7] ? K_DOT : kind_t'(rem[2:0]);
		end
		if (valid_s2) begin
			job_s3.kind <= kind_s2;
			job_s3.x    <= x_s2;
			job_s3.y    <= y_s2;
			job_s3.h    <= h_s2[FIELD_W-1:0];
			job_s3.v    <= v_s2[FIELD_W-1:0];
			job_s3.h4   <= h4_prod[DIV3_SHIFT +: FIELD_W];
			job_s3.v4   <= v4_prod[DIV3_SHIFT +: FIELD_W];
			job_s3.v2   <= v2_prod[DIV3_SHIFT +: FIELD_W];
		end
	end

	assign push = valid_s3;
	assign job  = job_s3;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= QCNT_W'(QDEPTH))
		else $error("credit count out of range");

	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> credit_q <= $past(credit_q))
		else $error("item taken while busy");

endmodule
`default_nettype wire

// ----- hw/rtl/pmsg_back.sv -----
// back end: steps through the stroke table and drives the pen command outputs
`default_nettype none
module pmsg_back
	import pmsg_pkg::*;
#(
	parameter int unsigned COORD_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire job_t        head,
	input  wire logic        empty,
	output logic             pop,
	output logic             strobe,
	output logic             pen_command,
	output logic [FIELD_W-1:0] out_x,
	output logic [FIELD_W-1:0] out_y,
	output logic             last_command
);

	localparam int unsigned CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam logic [FIELD_W-1:0] OUT_MASK = FIELD_W'((64'd1 << CW) - 64'd1);

	job_t              cur_q;
	logic [STEP_W-1:0] step_q;
	logic              active_q;
	cmd_t              cmd;
	logic [FIELD_W-1:0] tx;
	logic [FIELD_W-1:0] ty;

	logic               strobe_q;
	logic               pen_q;
	logic [FIELD_W-1:0] x_q;
	logic [FIELD_W-1:0] y_q;
	logic               last_q;

	assign cmd = stroke_cmd(cur_q.kind, step_q);
	assign pop = (!active_q || cmd.last) && !empty;

	always_comb begin
		case (cmd.xsel)
			XS_MH:   tx = cur_q.x - cur_q.h;
			XS_PH:   tx = cur_q.x + cur_q.h;
			XS_MH4:  tx = cur_q.x - cur_q.h4;
			XS_PH4:  tx = cur_q.x + cur_q.h4;
			default: tx = cur_q.x;
		endcase
		case (cmd.ysel)
			YS_MV:   ty = cur_q.y - cur_q.v;
			YS_PV:   ty = cur_q.y + cur_q.v;
			YS_PV4:  ty = cur_q.y + cur_q.v4;
			YS_MV2:  ty = cur_q.y - cur_q.v2;
			default: ty = cur_q.y;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q && cmd.last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (active_q) begin
			pen_q  <= cmd.pen;
			x_q    <= tx & OUT_MASK;
			y_q    <= ty & OUT_MASK;
			last_q <= cmd.last;
		end
	end

	assign strobe       = strobe_q;
	assign pen_command  = pen_q;
	assign out_x        = x_q;
	assign out_y        = y_q;
	assign last_command = last_q;

	a_marker_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q)
		else $error("marker commands interrupted");

	a_first_is_move: assert property (@(posedge clk) disable iff (!arst_n)
		$past(pop) |-> active_q && !cmd.pen)
		else $error("marker does not start with a move");

endmodule
`default_nettype wire

// ----- sim/stroke_checker.sv -----
// checker for the point marker stroke generator: predicts every pen command and compares
module stroke_checker
	import pmsg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [FIELD_W-1:0] x_pos,
	input  wire logic [FIELD_W-1:0] y_pos,
	input  wire logic [7:0]         symbol,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               strobe,
	input  wire logic               pen_command,
	input  wire logic [FIELD_W-1:0] out_x,
	input  wire logic [FIELD_W-1:0] out_y,
	input  wire logic               last_command,
	output int                      mismatches,
	output int                      outstanding
);

	localparam int MARKER_KINDS = 6;
	localparam logic PEN_MOVE = 1'b0;
	localparam logic PEN_DRAW = 1'b1;

	typedef struct {
		logic        pen;
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
	} stroke_t;

	stroke_t     due_strokes[$];
	stroke_t     head;
	logic [15:0] scale = 16'd256;
	logic [11:0] htic = 12'd100;
	logic [11:0] vtic = 12'd100;
	int          errs = 0;

	function automatic void put_stroke(input logic pen, input logic [15:0] x,
			input logic [15:0] y);
		stroke_t s;
		s.pen = pen;
		s.x = x;
		s.y = y;
		s.last = 1'b0;
		due_strokes.push_back(s);
	endfunction

	function automatic void trace_marker(input logic [15:0] cx, input logic [15:0] cy,
			input logic [7:0] sym);
		logic [31:0] h_full, v_full, h4, v4, v2;
		logic [15:0] xm, xp, ym, yp, xm4, xp4, yp4, ym2;
		kind_t kind;
		h_full = (32'(scale) * 32'(htic)) >> 9;
		v_full = (32'(scale) * 32'(vtic)) >> 9;
		h4 = (h_full * 32'd4) / 32'd3;
		v4 = (v_full * 32'd4) / 32'd3;
		v2 = (v_full * 32'd2) / 32'd3;
		xm = cx - h_full[15:0];
		xp = cx + h_full[15:0];
		ym = cy - v_full[15:0];
		yp = cy + v_full[15:0];
		xm4 = cx - h4[15:0];
		xp4 = cx + h4[15:0];
		yp4 = cy + v4[15:0];
		ym2 = cy - v2[15:0];
		if (sym[7])
			kind = K_DOT;
		else
			kind = kind_t'(3'(32'(sym[6:0]) % MARKER_KINDS));
		case (kind)
			K_PLUS: begin
				put_stroke(PEN_MOVE, xm, cy);
				put_stroke(PEN_DRAW, xm, cy);
				put_stroke(PEN_DRAW, xp, cy);
				put_stroke(PEN_MOVE, cx, ym);
				put_stroke(PEN_DRAW, cx, ym);
				put_stroke(PEN_DRAW, cx, yp);
			end
			K_CROSS: begin
				put_stroke(PEN_MOVE, xm, ym);
				put_stroke(PEN_DRAW, xm, ym);
				put_stroke(PEN_DRAW, xp, yp);
				put_stroke(PEN_MOVE, xm, yp);
				put_stroke(PEN_DRAW, xm, yp);
				put_stroke(PEN_DRAW, xp, ym);
			end
			K_STAR: begin
				put_stroke(PEN_MOVE, xm, cy);
				put_stroke(PEN_DRAW, xm, cy);
				put_stroke(PEN_DRAW, xp, cy);
				put_stroke(PEN_MOVE, cx, ym);
				put_stroke(PEN_DRAW, cx, ym);
				put_stroke(PEN_DRAW, cx, yp);
				put_stroke(PEN_MOVE, xm, ym);
				put_stroke(PEN_DRAW, xm, ym);
				put_stroke(PEN_DRAW, xp, yp);
				put_stroke(PEN_MOVE, xm, yp);
				put_stroke(PEN_DRAW, xm, yp);
				put_stroke(PEN_DRAW, xp, ym);
			end
			K_BOX: begin
				put_stroke(PEN_MOVE, xm, ym);
				put_stroke(PEN_DRAW, xm, ym);
				put_stroke(PEN_DRAW, xp, ym);
				put_stroke(PEN_DRAW, xp, yp);
				put_stroke(PEN_DRAW, xm, yp);
				put_stroke(PEN_DRAW, xm, ym);
				put_stroke(PEN_MOVE, cx, cy);
				put_stroke(PEN_DRAW, cx, cy);
			end
			K_DIAMOND: begin
				put_stroke(PEN_MOVE, xm, cy);
				put_stroke(PEN_DRAW, cx, ym);
				put_stroke(PEN_DRAW, xp, cy);
				put_stroke(PEN_DRAW, cx, yp);
				put_stroke(PEN_DRAW, xm, cy);
				put_stroke(PEN_MOVE, cx, cy);
				put_stroke(PEN_DRAW, cx, cy);
			end
			K_TRIANGLE: begin
				put_stroke(PEN_MOVE, cx, yp4);
				put_stroke(PEN_DRAW, xm4, ym2);
				put_stroke(PEN_DRAW, xp4, ym2);
				put_stroke(PEN_DRAW, cx, yp4);
				put_stroke(PEN_MOVE, cx, cy);
				put_stroke(PEN_DRAW, cx, cy);
			end
			default: begin
				put_stroke(PEN_MOVE, cx, cy);
				put_stroke(PEN_DRAW, cx, cy);
			end
		endcase
		due_strokes[due_strokes.size() - 1].last = 1'b1;
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			errs++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale = 16'd256;
			htic = 12'd100;
			vtic = 12'd100;
			due_strokes.delete();
		end else begin
			if (strobe) begin
				if (due_strokes.size() == 0) begin
					errs++;
					$display("%0t: command expected none actual pen %b x %h y %h last %b",
						$time, pen_command, out_x, out_y, last_command);
				end else begin
					head = due_strokes.pop_front();
					compare_field("pen_command", 16'(head.pen), 16'(pen_command));
					compare_field("out_x", head.x, out_x);
					compare_field("out_y", head.y, out_y);
					compare_field("last_command", 16'(head.last), 16'(last_command));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE: scale = cfg_data;
					REG_HTIC:  htic = cfg_data[11:0];
					REG_VTIC:  vtic = cfg_data[11:0];
					default: ;
				endcase
			end
			if (start && !busy)
				trace_marker(x_pos, y_pos, symbol);
		end
		mismatches <= errs;
		outstanding <= due_strokes.size();
	end

endmodule

// ----- sim/testbench.sv -----
// testbench top: drives markers and register writes into the stroke generator and reports
module testbench;
	import pmsg_pkg::*;

	localparam logic [1:0] REG_NONE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [FIELD_W-1:0] x_pos = '0;
	logic [FIELD_W-1:0] y_pos = '0;
	logic signed [7:0]  symbol = '0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               strobe;
	logic               pen_command;
	logic [FIELD_W-1:0] out_x;
	logic [FIELD_W-1:0] out_y;
	logic               last_command;
	int                 mismatches;
	int                 outstanding;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	point_marker_stroke_generator_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_pos(x_pos), .y_pos(y_pos), .symbol(symbol),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .pen_command(pen_command), .out_x(out_x), .out_y(out_y),
		.last_command(last_command)
	);

	stroke_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_pos(x_pos), .y_pos(y_pos), .symbol(symbol),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .pen_command(pen_command), .out_x(out_x), .out_y(out_y),
		.last_command(last_command), .mismatches(mismatches), .outstanding(outstanding)
	);

	// holds start until the marker transfer happens
	task automatic send_marker(input logic [15:0] x, input logic [15:0] y,
			input logic [7:0] sym);
		start <= 1'b1;
		x_pos <= x;
		y_pos <= y;
		symbol <= sym;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [15:0] s, input logic [15:0] ht,
			input logic [15:0] vt);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCALE;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= REG_HTIC;
		cfg_data <= ht;
		@(posedge clk);
		cfg_index <= REG_VTIC;
		cfg_data <= vt;
		@(posedge clk);
		// out of range index, must be dropped
		cfg_index <= REG_NONE;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_bursts(input int count);
		int left, burst, gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			for (int i = 0; i < burst && left > 0; i++) begin
				send_marker(16'($urandom), 16'($urandom), 8'($urandom));
				left--;
			end
		end
		settle();
	endtask

	task automatic run_phase(input logic [15:0] s, input logic [15:0] ht,
			input logic [15:0] vt, input int count);
		write_regs(s, ht, vt);
		send_bursts(count);
	endtask

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every kind, dot, symbol extremes and coordinate wrap
		send_marker(16'd1000, 16'd1000, 8'sd0);
		send_marker(16'd1000, 16'd1000, 8'sd1);
		send_marker(16'd1000, 16'd1000, 8'sd2);
		send_marker(16'd1000, 16'd1000, 8'sd3);
		send_marker(16'd1000, 16'd1000, 8'sd4);
		send_marker(16'd1000, 16'd1000, 8'sd5);
		send_marker(16'd1000, 16'd1000, -8'sd1);
		send_marker(16'h0000, 16'h0000, -8'sd128);
		send_marker(16'hffff, 16'hffff, 8'sd127);
		send_marker(16'h0000, 16'hffff, 8'sd6);
		send_marker(16'd20, 16'd30, 8'sd5);
		send_marker(16'hffff, 16'h0000, 8'sd2);
		send_marker(16'h5555, 16'haaaa, 8'sd126);
		send_marker(16'haaaa, 16'h5555, 8'sd11);
		send_marker(16'd10, 16'd10, 8'sd3);
		send_marker(16'd65530, 16'd5, 8'sd4);
		settle();

		send_bursts(40);
		run_phase(16'd0, 16'd4095, 16'd4095, 40);
		run_phase(16'd65535, 16'd4095, 16'd4095, 40);
		run_phase(16'd256, 16'd0, 16'd0, 30);
		run_phase(16'd65535, 16'd0, 16'hffff, 40);
		run_phase(16'd1, 16'd1, 16'd1, 30);
		run_phase(16'd512, 16'd100, 16'd37, 40);
		for (int p = 0; p < 3; p++)
			run_phase(16'($urandom), 16'($urandom), 16'($urandom), 45);
		run_phase(16'd256, 16'd100, 16'd100, 20);

		repeat (12) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- point_marker_stroke_generator_top.f -----
hw/rtl/pmsg_pkg.sv
hw/rtl/pmsg_queue.sv
hw/rtl/pmsg_front.sv
hw/rtl/pmsg_back.sv
hw/rtl/point_marker_stroke_generator_top.sv
sim/stroke_checker.sv
sim/testbench.sv
